[hw/rtl/register_pair_execute_unit_defines.svh]
// Assertion macros shared by the checker of the register pair execute unit.
// Standalone header, no dependencies.
`ifndef REGISTER_PAIR_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_PAIR_EXECUTE_UNIT_DEFINES_SVH

// Concurrent assertion, switched off while reset is held
`define RPEU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that is also checked across reset
`define RPEU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hw/rtl/rpeu_pkg.sv]
// Shared types, constants and helpers of the register pair execute unit.
// No dependencies.
package rpeu_pkg;

  // Memory address width default
  localparam int ADDR_BITS_DEF = 16;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 88;

  // Output field offsets in out_tdata
  localparam int OUT_BC_LSB    = 0;
  localparam int OUT_DE_LSB    = 16;
  localparam int OUT_HL_LSB    = 32;
  localparam int OUT_SP_LSB    = 48;
  localparam int OUT_CARRY_BIT = 64;
  localparam int OUT_PC_LSB    = 65;
  localparam int OUT_CYC_LSB   = 81;

  // Command queue depth (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Mode field codes
  localparam logic [2:0] MODE_DAD  = 3'd0;
  localparam logic [2:0] MODE_INX  = 3'd1;
  localparam logic [2:0] MODE_DCX  = 3'd2;
  localparam logic [2:0] MODE_XCHG = 3'd3;
  localparam logic [2:0] MODE_XTHL = 3'd4;
  localparam logic [2:0] MODE_SPHL = 3'd5;

  // Pair field codes
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  // Machine cycle counts reported per instruction
  localparam logic [4:0] CYC_DAD  = 5'd10;
  localparam logic [4:0] CYC_INX  = 5'd5;
  localparam logic [4:0] CYC_DCX  = 5'd5;
  localparam logic [4:0] CYC_XCHG = 5'd4;
  localparam logic [4:0] CYC_XTHL = 5'd18;
  localparam logic [4:0] CYC_SPHL = 5'd5;
  localparam logic [4:0] CYC_NOP  = 5'd4;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_DAD,
    OP_INX,
    OP_DCX,
    OP_XCHG,
    OP_XTHL,
    OP_SPHL,
    OP_NOP
  } op_t;

  // Decoded command as held in the queue
  typedef struct packed {
    op_t        op;
    logic [1:0] pair;
    logic [4:0] cycles;
  } cmd_t;

  // Command request between stages
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  function automatic logic [4:0] cycles_of(op_t op);
    logic [4:0] c;
    unique case (op)
      OP_DAD:  c = CYC_DAD;
      OP_INX:  c = CYC_INX;
      OP_DCX:  c = CYC_DCX;
      OP_XCHG: c = CYC_XCHG;
      OP_XTHL: c = CYC_XTHL;
      OP_SPHL: c = CYC_SPHL;
      default: c = CYC_NOP;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/rpeu_front.sv]
// Front end: accepts input requests and decodes them into queue commands.
// Depends on rpeu_pkg.
module rpeu_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rpeu_pkg::IN_TDATA_W-1:0]    in_tdata,   // [2:0] mode, [4:3] pair
  input  logic                               q_full,
  input  logic                               clear_busy,
  output rpeu_pkg::cmd_req_t                 push
);
  import rpeu_pkg::*;

  logic [2:0] mode;
  op_t        op;

  assign mode = in_tdata[2:0];

  // Take a request only when the queue has room and the memory is cleared
  assign in_tready = !q_full && !clear_busy;

  // Mode decode; unused codes act as a no-op
  always_comb begin
    unique case (mode)
      MODE_DAD:  op = OP_DAD;
      MODE_INX:  op = OP_INX;
      MODE_DCX:  op = OP_DCX;
      MODE_XCHG: op = OP_XCHG;
      MODE_XTHL: op = OP_XTHL;
      MODE_SPHL: op = OP_SPHL;
      default:   op = OP_NOP;
    endcase
  end

  assign push.valid      = in_tvalid && in_tready;
  assign push.cmd.op     = op;
  assign push.cmd.pair   = in_tdata[4:3];
  assign push.cmd.cycles = cycles_of(op);

endmodule

[hw/rtl/rpeu_queue.sv]
// Short command queue decoupling the front end from the execute stage.
// Depends on rpeu_pkg.
module rpeu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  rpeu_pkg::cmd_req_t push,
  output logic               full,
  output rpeu_pkg::cmd_req_t head,
  input  logic               pop
);
  import rpeu_pkg::*;

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = entries_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries_r[wr_ptr_r] <= push.cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push.valid && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push.valid && do_pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/rpeu_back.sv]
// Execute stage: register file, byte memory with clearing pass, result register.
// Depends on rpeu_pkg.
module rpeu_back #(
  parameter int ADDR_BITS = rpeu_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpeu_pkg::cmd_req_t                head,
  output logic                              pop,
  output logic                              clear_busy,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rpeu_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rpeu_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_X1,
    ST_X2
  } state_t;

  state_t state_r;

  // Architectural registers
  logic [15:0] bc_r, de_r, hl_r, sp_r, pc_r;
  logic        carry_r;
  logic [15:0] bc_nxt, de_nxt, hl_nxt, sp_nxt, pc_nxt;
  logic        carry_nxt;

  // Byte memory and its ports
  logic [7:0]           mem [2**ADDR_BITS];
  logic [7:0]           mem_rd_r;
  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_wa, mem_ra, clr_addr_r;
  logic [7:0]           mem_wd;
  logic [ADDR_BITS-1:0] addr_lo, addr_hi;
  logic [15:0]          sp_inc;

  // Result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   slot_free;
  logic                   emit;

  // Execute datapath helpers
  logic [15:0] pair_val, pair_upd;
  logic [16:0] dad_sum;

  assign slot_free  = !out_valid_r || out_tready;
  assign clear_busy = (state_r == ST_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign pop        = emit;

  assign sp_inc  = sp_r + 16'd1;
  assign addr_lo = sp_r[ADDR_BITS-1:0];
  assign addr_hi = sp_inc[ADDR_BITS-1:0];

  // Selected pair and its arithmetic
  always_comb begin
    unique case (head.cmd.pair)
      PAIR_BC: pair_val = bc_r;
      PAIR_DE: pair_val = de_r;
      PAIR_HL: pair_val = hl_r;
      PAIR_SP: pair_val = sp_r;
      default: pair_val = sp_r;
    endcase
    dad_sum  = {1'b0, hl_r} + {1'b0, pair_val};
    pair_upd = (head.cmd.op == OP_INX) ? pair_val + 16'd1 : pair_val - 16'd1;
  end

  // Next register values for the command at the queue head
  always_comb begin
    bc_nxt    = bc_r;
    de_nxt    = de_r;
    hl_nxt    = hl_r;
    sp_nxt    = sp_r;
    carry_nxt = carry_r;
    pc_nxt    = pc_r + 16'd1;
    unique case (head.cmd.op)
      OP_DAD: begin
        hl_nxt    = dad_sum[15:0];
        carry_nxt = dad_sum[16];
      end
      OP_INX, OP_DCX: begin
        unique case (head.cmd.pair)
          PAIR_BC: bc_nxt = pair_upd;
          PAIR_DE: de_nxt = pair_upd;
          PAIR_HL: hl_nxt = pair_upd;
          PAIR_SP: sp_nxt = pair_upd;
          default: sp_nxt = pair_upd;
        endcase
      end
      OP_XCHG: begin
        hl_nxt = de_r;
        de_nxt = hl_r;
      end
      // low byte already swapped in, high byte arrives now
      OP_XTHL: hl_nxt = {mem_rd_r, hl_r[7:0]};
      OP_SPHL: sp_nxt = hl_r;
      OP_NOP:  ;
      default: ;
    endcase
  end

  // Sequencing: memory port use and result issue
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr_r;
    mem_wd = 8'h00;
    mem_re = 1'b0;
    mem_ra = addr_lo;
    emit   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RUN: begin
        if (head.valid) begin
          if (head.cmd.op == OP_XTHL) begin
            // read old low byte, store L in its place
            mem_re = 1'b1;
            mem_we = 1'b1;
            mem_wa = addr_lo;
            mem_wd = hl_r[7:0];
          end else begin
            emit = slot_free;
          end
        end
      end
      ST_X1: begin
        mem_re = 1'b1;
        mem_ra = addr_hi;
        mem_we = 1'b1;
        mem_wa = addr_hi;
        mem_wd = hl_r[15:8];
      end
      ST_X2: begin
        emit = slot_free;
      end
      default: ;
    endcase
  end

  // Byte memory, read returns the value before a write in the same cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  // State, registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      bc_r        <= '0;
      de_r        <= '0;
      hl_r        <= '0;
      sp_r        <= '0;
      pc_r        <= '0;
      carry_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_BITS'(1);
          if (clr_addr_r == '1) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (head.valid && head.cmd.op == OP_XTHL) begin
            state_r <= ST_X1;
          end
        end
        ST_X1: begin
          hl_r[7:0] <= mem_rd_r;
          state_r   <= ST_X2;
        end
        ST_X2: begin
          if (slot_free) begin
            state_r <= ST_RUN;
          end
        end
        default: state_r <= ST_RUN;
      endcase

      if (emit) begin
        bc_r        <= bc_nxt;
        de_r        <= de_nxt;
        hl_r        <= hl_nxt;
        sp_r        <= sp_nxt;
        pc_r        <= pc_nxt;
        carry_r     <= carry_nxt;
        out_valid_r <= 1'b1;
        out_data_r  <= {2'b00, head.cmd.cycles, pc_nxt, carry_nxt,
                        sp_nxt, hl_nxt, de_nxt, bc_nxt};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/register_pair_execute_unit.sv]
// Register pair execute unit: ties front end, command queue and execute stage.
// Depends on rpeu_pkg, rpeu_front, rpeu_queue and rpeu_back.
//
// Usage:
//   in_*  carries one instruction request per transfer: mode and pair fields.
//   out_* carries one result per request: BC, DE, HL, SP, carry, PC and the
//   instruction's machine cycle count, in request order.
//   After reset the byte memory is swept to zero, one byte a cycle, over all
//   2^ADDR_BITS addresses; in_tready stays low until the sweep ends and all
//   registers read zero. A request is written into the queue, then executed
//   from the queue head into the result register that drives out_tvalid;
//   XTHL passes through states ST_X1 and ST_X2 before its result is issued.
//   Throughput: one request per cycle while the receiver keeps up and no
//   XTHL is in the execute stage; XTHL holds it in ST_RUN, ST_X1 and ST_X2,
//   as its two byte reads and two byte writes share the memory's one read
//   port and one write port. A stalled receiver holds the result register;
//   the queue keeps taking requests until it is full, then in_tready drops.
module register_pair_execute_unit #(
  parameter int ADDR_BITS = rpeu_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rpeu_pkg::IN_TDATA_W-1:0]   in_tdata,   // mode[2:0], pair[4:3], zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // bc[15:0], de[31:16], hl[47:32], sp[63:48], carry[64], pc[80:65],
  // cycles[85:81], zero pad
  output logic [rpeu_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rpeu_pkg::*;

  cmd_req_t push;
  cmd_req_t head;
  logic     q_full;
  logic     pop;
  logic     clear_busy;

  rpeu_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .clear_busy (clear_busy),
    .push       (push)
  );

  rpeu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  rpeu_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[hw/rtl/rpeu_checker.sv]
// Port-level checker for the register pair execute unit, bound to the top level.
// Depends on rpeu_pkg and register_pair_execute_unit_defines.svh.
`include "register_pair_execute_unit_defines.svh"

module rpeu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rpeu_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rpeu_pkg::*;

  logic [15:0] pc_out, last_pc_r;
  logic [4:0]  cyc_out;
  logic        carry_out, last_carry_r;

  assign pc_out    = out_tdata[OUT_PC_LSB +: 16];
  assign cyc_out   = out_tdata[OUT_CYC_LSB +: 5];
  assign carry_out = out_tdata[OUT_CARRY_BIT];

  // Last delivered PC and carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pc_r    <= '0;
      last_carry_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_pc_r    <= pc_out;
      last_carry_r <= carry_out;
    end
  end

  `RPEU_ASSERT(a_stall_hold, clk, rst_n,
               (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)),
               "result changed while stalled")
  `RPEU_ASSERT(a_pc_step, clk, rst_n,
               out_tvalid |-> (pc_out == last_pc_r + 16'd1),
               "pc did not advance by one")
  `RPEU_ASSERT(a_carry_dad_only, clk, rst_n,
               (out_tvalid && cyc_out != CYC_DAD) |-> (carry_out == last_carry_r),
               "carry changed outside dad")
  `RPEU_ASSERT(a_cycles_legal, clk, rst_n,
               out_tvalid |-> (cyc_out == CYC_DAD || cyc_out == CYC_INX ||
                               cyc_out == CYC_XCHG || cyc_out == CYC_XTHL),
               "illegal cycle count")
  `RPEU_ASSERT_ALWAYS(a_reset_quiet, clk,
                      !rst_n |=> (!in_tready && !out_tvalid),
                      "ports active after reset")

endmodule

bind register_pair_execute_unit rpeu_checker u_rpeu_checker (.*);
